// ===== rtl/core/spr_pkg.sv =====
// spectral peak ranker package: widths, ranking depth and the rank request
// type passed from the tracker to the chain of rank cells
// no dependencies
`default_nettype none

package spr_pkg;

  localparam int unsigned LevelWidth   = 32;
  localparam int unsigned BinWidth     = 16;
  localparam int unsigned SpectrumSize = 65536;
  localparam int unsigned NumLevels    = 5;
  localparam int unsigned NumBins      = 3;

  typedef logic [LevelWidth-1:0] level_t;
  typedef logic [BinWidth-1:0]   bin_t;

  localparam bin_t StartBinReset = bin_t'(20);

  // one transaction worth of work for the rank cells
  typedef struct packed {
    logic   vld;
    logic   clr;
    logic   rank;
    logic   last;
    bin_t   bin;
    level_t level;
  } req_t;

endpackage

`default_nettype wire

// ===== rtl/core/spr_in_if.sv =====
// input channel of the spectral peak ranker: one magnitude bin per transaction
// depends on spr_pkg
`default_nettype none

interface spr_in_if;
  logic              valid;
  logic              ready;
  spr_pkg::level_t   magnitude;
  logic              frame_first;
  logic              frame_last;

  modport source (output valid, magnitude, frame_first, frame_last, input ready);
  modport sink   (input valid, magnitude, frame_first, frame_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spr_out_if.sv =====
// output channel of the spectral peak ranker: ranked peaks of one frame
// depends on spr_pkg
`default_nettype none

interface spr_out_if;
  logic            valid;
  logic            ready;
  spr_pkg::bin_t   peak1_bin;
  spr_pkg::level_t peak1_level;
  spr_pkg::bin_t   peak2_bin;
  spr_pkg::level_t peak2_level;
  spr_pkg::bin_t   peak3_bin;
  spr_pkg::level_t peak3_level;
  spr_pkg::level_t level4;
  spr_pkg::level_t level5;

  modport source (output valid, peak1_bin, peak1_level, peak2_bin, peak2_level,
                  peak3_bin, peak3_level, level4, level5, input ready);
  modport sink   (input valid, peak1_bin, peak1_level, peak2_bin, peak2_level,
                  peak3_bin, peak3_level, level4, level5, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/spectral_peak_top_ranker.sv =====
// top level of the spectral peak ranker: tracker, chain of rank cells and
// output register; depends on spr_pkg, spr_in_if, spr_out_if, spr_tracker, spr_rank_cell
`default_nettype none

// Spectral peak ranker. Accepts one magnitude bin per clock cycle with no
// bubbles while input ready is high. A transaction goes through two register
// stages: the tracker finds local maxima in the cycle it accepts a bin, and
// the chain of five rank cells inserts a qualifying peak when the tracker's
// request advances. The result of a frame_last bin is loaded into the output
// register as its request advances. Input ready drops only while a frame_last
// transaction sits in the cell stage and the previous result has not been
// taken. start_bin takes effect at the next frame_first; after reset it is 20.
module spectral_peak_top_ranker (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire spr_pkg::bin_t cfg_wdata_i,
  spr_in_if.sink             in_i,
  spr_out_if.source          out_o
);

  localparam int unsigned NumCells = spr_pkg::NumLevels;

  spr_pkg::req_t   req;
  logic            accept, stall, adv, load;
  logic            out_vld_q;
  logic            gt     [NumCells];
  spr_pkg::level_t lvl    [NumCells];
  spr_pkg::bin_t   bin    [NumCells];
  spr_pkg::level_t lvl_d  [NumCells];
  spr_pkg::bin_t   bin_d  [NumCells];
  spr_pkg::level_t out_lvl_q [NumCells];
  spr_pkg::bin_t   out_bin_q [spr_pkg::NumBins];

  assign stall      = req.vld && req.last && out_vld_q && !out_o.ready;
  assign adv        = !stall;
  assign load       = req.vld && req.last && adv;
  assign in_i.ready = adv;
  assign accept     = in_i.valid && in_i.ready;

  spr_tracker u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .adv_i         (adv),
    .magnitude_i   (in_i.magnitude),
    .frame_first_i (in_i.frame_first),
    .frame_last_i  (in_i.frame_last),
    .req_o         (req)
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    spr_rank_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (req.vld && adv),
      .req_i        (req),
      .left_gt_i    ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
      .left_level_i ((i == 0) ? '0 : lvl[(i == 0) ? 0 : i - 1]),
      .left_bin_i   ((i == 0) ? '0 : bin[(i == 0) ? 0 : i - 1]),
      .gt_o         (gt[i]),
      .level_o      (lvl[i]),
      .bin_o        (bin[i]),
      .level_d_o    (lvl_d[i]),
      .bin_d_o      (bin_d[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // result payload comes straight from the cells' next state
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < NumCells; i++) begin
        out_lvl_q[i] <= lvl_d[i];
      end
      for (int i = 0; i < spr_pkg::NumBins; i++) begin
        out_bin_q[i] <= bin_d[i];
      end
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.peak1_bin   = out_bin_q[0];
  assign out_o.peak1_level = out_lvl_q[0];
  assign out_o.peak2_bin   = out_bin_q[1];
  assign out_o.peak2_level = out_lvl_q[1];
  assign out_o.peak3_bin   = out_bin_q[2];
  assign out_o.peak3_level = out_lvl_q[2];
  assign out_o.level4      = out_lvl_q[3];
  assign out_o.level5      = out_lvl_q[4];

endmodule

`default_nettype wire

// ===== rtl/core/spr_tracker.sv =====
// rise/fall tracker: finds local maxima and issues rank requests to the cells
// depends on spr_pkg
`default_nettype none

module spr_tracker (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire spr_pkg::bin_t   cfg_wdata_i,
  input  wire logic            accept_i,
  input  wire logic            adv_i,
  input  wire spr_pkg::level_t magnitude_i,
  input  wire logic            frame_first_i,
  input  wire logic            frame_last_i,
  output spr_pkg::req_t        req_o
);

  spr_pkg::bin_t   start_bin_q;
  spr_pkg::level_t prev_level_q, prev_level_d;
  spr_pkg::level_t peak_level_q, peak_level_d;
  spr_pkg::bin_t   peak_bin_q, peak_bin_d;
  logic            rising_q, rising_d;
  logic            peak_rising_q, peak_rising_d;
  spr_pkg::bin_t   cnt_q, cnt_d;
  spr_pkg::req_t   req_q, req_d;

  spr_pkg::level_t lvl, plvl;
  spr_pkg::bin_t   pbin, cnt, max_bin;
  logic            ris, pris, det, peak_gt;
  logic [spr_pkg::BinWidth:0] cnt_inc;

  always_comb begin
    // frame_first clears the tracking state before this bin
    lvl  = frame_first_i ? '0 : prev_level_q;
    plvl = frame_first_i ? '0 : peak_level_q;
    pbin = frame_first_i ? '0 : peak_bin_q;
    ris  = frame_first_i | rising_q;
    pris = frame_first_i | peak_rising_q;
    cnt  = frame_first_i ? start_bin_q : cnt_q;

    det     = ris && (lvl > magnitude_i);
    peak_gt = plvl > lvl;
    max_bin = (cnt == '0) ? spr_pkg::bin_t'(spr_pkg::SpectrumSize - 1) : cnt - 1'b1;

    prev_level_d  = magnitude_i;
    peak_level_d  = det ? lvl : plvl;
    peak_bin_d    = det ? max_bin : pbin;
    peak_rising_d = det ? !peak_gt : pris;
    rising_d      = (magnitude_i > lvl) ? 1'b1 : (det ? 1'b0 : ris);

    cnt_inc = {1'b0, cnt} + 1'b1;
    cnt_d   = (32'(cnt_inc) >= spr_pkg::SpectrumSize) ? '0
                                                      : cnt_inc[spr_pkg::BinWidth-1:0];

    req_d.vld   = accept_i;
    req_d.clr   = frame_first_i;
    req_d.rank  = det && pris && peak_gt;
    req_d.last  = frame_last_i;
    req_d.bin   = pbin;
    req_d.level = plvl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_bin_q   <= spr_pkg::StartBinReset;
      prev_level_q  <= '0;
      peak_level_q  <= '0;
      peak_bin_q    <= '0;
      rising_q      <= 1'b1;
      peak_rising_q <= 1'b1;
      cnt_q         <= spr_pkg::StartBinReset;
      req_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        start_bin_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        prev_level_q  <= prev_level_d;
        peak_level_q  <= peak_level_d;
        peak_bin_q    <= peak_bin_d;
        rising_q      <= rising_d;
        peak_rising_q <= peak_rising_d;
        cnt_q         <= cnt_d;
      end
      if (adv_i) begin
        req_q <= req_d;
      end
    end
  end

  assign req_o = req_q;

endmodule

`default_nettype wire

// ===== rtl/core/spr_rank_cell.sv =====
// one cell of the insertion chain: holds one ranked level and its bin,
// takes the new peak or its left neighbor's entry when the peak is inserted
// depends on spr_pkg
`default_nettype none

module spr_rank_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire spr_pkg::req_t   req_i,
  input  wire logic            left_gt_i,
  input  wire spr_pkg::level_t left_level_i,
  input  wire spr_pkg::bin_t   left_bin_i,
  output logic                 gt_o,
  output spr_pkg::level_t      level_o,
  output spr_pkg::bin_t        bin_o,
  output spr_pkg::level_t      level_d_o,
  output spr_pkg::bin_t        bin_d_o
);

  spr_pkg::level_t level_q, level_d;
  spr_pkg::bin_t   bin_q, bin_d;
  logic            take_new, take_left;

  always_comb begin
    level_o = req_i.clr ? '0 : level_q;
    bin_o   = req_i.clr ? '0 : bin_q;
    gt_o    = req_i.level > level_o;
    // chain is sorted, so gt is monotonic: the first cell with gt takes the
    // new peak and everything right of it shifts by one
    take_new  = req_i.rank && gt_o && !left_gt_i;
    take_left = req_i.rank && left_gt_i;
    level_d   = take_new ? req_i.level : (take_left ? left_level_i : level_o);
    bin_d     = take_new ? req_i.bin   : (take_left ? left_bin_i   : bin_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= '0;
      bin_q   <= '0;
    end else if (en_i) begin
      level_q <= level_d;
      bin_q   <= bin_d;
    end
  end

  assign level_d_o = level_d;
  assign bin_d_o   = bin_d;

endmodule

`default_nettype wire

// ===== rtl/core/spr_checker.sv =====
// port level checks of the spectral peak ranker and the bind that attaches them
// depends on spr_pkg and spectral_peak_top_ranker
`default_nettype none

module spr_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_i,
  input wire logic            in_last_i,
  input wire logic            out_valid_i,
  input wire logic            out_ready_i,
  input wire spr_pkg::bin_t   p1_bin_i,
  input wire spr_pkg::level_t p1_lvl_i,
  input wire spr_pkg::bin_t   p2_bin_i,
  input wire spr_pkg::level_t p2_lvl_i,
  input wire spr_pkg::bin_t   p3_bin_i,
  input wire spr_pkg::level_t p3_lvl_i,
  input wire spr_pkg::level_t lvl4_i,
  input wire spr_pkg::level_t lvl5_i
);

  // a held result stays valid and keeps peak1's level and bin and level5
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(p1_lvl_i) && $stable(p1_bin_i)
                                    && $stable(lvl5_i))
    else $error("result changed while stalled");

  // ranked levels are never increasing
  a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (p1_lvl_i >= p2_lvl_i) && (p2_lvl_i >= p3_lvl_i)
                    && (p3_lvl_i >= lvl4_i) && (lvl4_i >= lvl5_i))
    else $error("ranked levels out of order");

  // an empty rank reports bin zero
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (p1_lvl_i != '0 || p1_bin_i == '0) && (p2_lvl_i != '0 || p2_bin_i == '0)
                    && (p3_lvl_i != '0 || p3_bin_i == '0))
    else $error("empty rank with nonzero bin");

  // a new result follows an accepted frame_last transaction
  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i, 2))
    else $error("result without a frame_last transaction");

endmodule

bind spectral_peak_top_ranker spr_checker u_spr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.frame_last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .p1_bin_i    (out_o.peak1_bin),
  .p1_lvl_i    (out_o.peak1_level),
  .p2_bin_i    (out_o.peak2_bin),
  .p2_lvl_i    (out_o.peak2_level),
  .p3_bin_i    (out_o.peak3_bin),
  .p3_lvl_i    (out_o.peak3_level),
  .lvl4_i      (out_o.level4),
  .lvl5_i      (out_o.level5)
);

`default_nettype wire
